[rtl/u16s_pkg.sv]
// shared types and constants for the utf-16be message text splitter
package u16s_pkg;

  // control sequence marker unit
  localparam logic [15:0] CtrlMarker = 16'h001A;

  // result status codes
  localparam logic [2:0] StUnit    = 3'd0;
  localparam logic [2:0] StTerm    = 3'd1;
  localparam logic [2:0] StTrunc   = 3'd2;
  localparam logic [2:0] StBadSize = 3'd3;
  localparam logic [2:0] StUnterm  = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_start;
    logic       data_end;
  } in_word_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        to_raw;
    logic        to_display;
    logic [2:0]  status;
    logic        message_done;
  } out_word_t;

  // classified byte: an optional unit, then an optional final status
  typedef struct packed {
    logic        unit_v;
    logic [15:0] unit;
    logic        disp;
    logic        fin_v;
    logic [2:0]  fin_status;
  } q_entry_t;

endpackage

[rtl/u16s_front.sv]
// front end: byte parser that classifies words into queue entries; words that complete no unit or status push nothing
module u16s_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  u16s_pkg::in_word_t in_word_i,
  input  logic               q_full_i,
  output logic               push_o,
  output u16s_pkg::q_entry_t push_entry_o
);
  import u16s_pkg::*;

  typedef enum logic [2:0] {
    PhIdle    = 3'd0,
    PhTxtHi   = 3'd1,
    PhTxtLo   = 3'd2,
    PhCtlSize = 3'd3,
    PhCtlHi   = 3'd4,
    PhCtlLo   = 3'd5
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] pend_q, pend_d;
  logic [7:0] left_q, left_d;
  q_entry_t   entry;

  assign in_ready_o = !q_full_i;

  always_comb begin
    phase_e      ph;
    logic [7:0]  lft;
    logic [7:0]  b;
    logic        fin_end;
    logic        ctl_hi;
    logic [15:0] unit;

    phase_d = phase_q;
    pend_d  = pend_q;
    left_d  = left_q;
    entry   = '0;
    push_o  = 1'b0;
    b       = in_word_i.data_byte;
    fin_end = in_word_i.data_end;
    ctl_hi  = 1'b0;
    lft     = left_q;
    ph      = phase_q;
    unit    = {pend_q, b};

    if (in_valid_i && in_ready_o) begin
      if (in_word_i.message_start) begin
        ph   = PhTxtHi;
        lft  = 8'd0;
        unit = {8'd0, b};
      end
      case (ph)
        PhTxtHi: begin
          pend_d  = b;
          phase_d = PhTxtLo;
          if (fin_end) begin
            entry.fin_v      = 1'b1;
            entry.fin_status = StUnterm;
          end
        end
        PhTxtLo: begin
          if (unit == 16'd0) begin
            entry.fin_v      = 1'b1;
            entry.fin_status = StTerm;
          end else if (unit == CtrlMarker) begin
            entry.unit_v = 1'b1;
            entry.unit   = unit;
            entry.disp   = 1'b0;
            phase_d      = PhCtlSize;
            if (fin_end) begin
              entry.fin_v      = 1'b1;
              entry.fin_status = StTrunc;
            end
          end else begin
            entry.unit_v = 1'b1;
            entry.unit   = unit;
            entry.disp   = 1'b1;
            phase_d      = PhTxtHi;
            if (fin_end) begin
              entry.fin_v      = 1'b1;
              entry.fin_status = StUnterm;
            end
          end
        end
        PhCtlSize: begin
          if (b < 8'd2) begin
            entry.fin_v      = 1'b1;
            entry.fin_status = StBadSize;
          end else if (b == 8'd2) begin
            // empty control sequence: size byte reused as text high byte
            pend_d  = b;
            phase_d = PhTxtLo;
            if (fin_end) begin
              entry.fin_v      = 1'b1;
              entry.fin_status = StUnterm;
            end
          end else begin
            lft    = b - 8'd2;
            ctl_hi = 1'b1;
          end
        end
        PhCtlHi: begin
          ctl_hi = 1'b1;
        end
        PhCtlLo: begin
          entry.unit_v = 1'b1;
          entry.unit   = unit;
          entry.disp   = 1'b0;
          if (lft != 8'd0) begin
            lft = lft - 8'd1;
          end
          left_d = lft;
          if (lft == 8'd0) begin
            phase_d = PhTxtHi;
            if (fin_end) begin
              entry.fin_v      = 1'b1;
              entry.fin_status = StUnterm;
            end
          end else begin
            phase_d = PhCtlHi;
            if (fin_end) begin
              entry.fin_v      = 1'b1;
              entry.fin_status = StBadSize;
            end
          end
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase

      // high byte of a control payload pair
      if (ctl_hi) begin
        if (lft <= 8'd1) begin
          // odd trailing payload byte is dropped
          left_d  = 8'd0;
          phase_d = PhTxtHi;
          if (fin_end) begin
            entry.fin_v      = 1'b1;
            entry.fin_status = StUnterm;
          end
        end else begin
          pend_d  = b;
          left_d  = lft - 8'd1;
          phase_d = PhCtlLo;
          if (fin_end) begin
            entry.fin_v      = 1'b1;
            entry.fin_status = StBadSize;
          end
        end
      end

      if (entry.fin_v) begin
        phase_d = PhIdle;
        pend_d  = 8'd0;
        left_d  = 8'd0;
      end
      push_o = entry.unit_v | entry.fin_v;
    end
  end

  assign push_entry_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      pend_q  <= 8'd0;
      left_q  <= 8'd0;
    end else begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
      left_q  <= left_d;
    end
  end

endmodule

[rtl/u16s_queue.sv]
// small register queue between front end and back end
module u16s_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  u16s_pkg::q_entry_t push_entry_i,
  output logic               full_o,
  output logic               head_valid_o,
  output u16s_pkg::q_entry_t head_o,
  input  logic               pop_i
);
  import u16s_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  q_entry_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  assign full_o       = (cnt_q == FullCnt);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[rtl/u16s_back.sv]
// back end: expands queue entries into result words behind an output register
module u16s_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  u16s_pkg::q_entry_t  head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output u16s_pkg::out_word_t out_word_o
);
  import u16s_pkg::*;

  logic      out_valid_q;
  out_word_t out_q, out_d;
  logic      half_q, half_d;
  logic      load;

  assign load = head_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    out_d  = '0;
    half_d = half_q;
    pop_o  = 1'b0;
    if (head_i.unit_v && !half_q) begin
      out_d.code_unit  = head_i.unit;
      out_d.to_raw     = 1'b1;
      out_d.to_display = head_i.disp;
      out_d.status     = StUnit;
    end else begin
      out_d.status       = head_i.fin_status;
      out_d.message_done = 1'b1;
    end
    if (load) begin
      if (head_i.unit_v && head_i.fin_v && !half_q) begin
        half_d = 1'b1;
      end else begin
        half_d = 1'b0;
        pop_o  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      half_q      <= 1'b0;
    end else begin
      half_q <= half_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

[rtl/utf16be_message_text_splitter.sv]
// top level of the utf-16be message text splitter
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+---------------------------------
//   in      | input     | in_valid_i / in_ready_o | data_byte, message_start, data_end
//   out     | output    | out_valid_o/out_ready_i | code_unit, to_raw, to_display,
//           |           |                         | status, message_done
//
// one input word per cycle while the entry queue is not full; a word causing two results yields two result words
// a taken word's first result reaches the output through the queue and then the out reg
// async active-low reset returns the parser to idle and empties the queue
// input stalls only when the entry queue is full; output stalls back up into it
// words that cause no result are taken without touching the queue
module utf16be_message_text_splitter #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  u16s_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output u16s_pkg::out_word_t out_word_o
);
  import u16s_pkg::*;

  // front to queue
  logic     push;
  q_entry_t push_entry;
  logic     q_full;
  // queue to back
  logic     head_valid;
  q_entry_t head;
  logic     pop;

  // byte parser: phase, pending high byte and control byte count
  u16s_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // decouples parser from output backpressure
  u16s_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // emits unit then final status, one result word per cycle while the output is not stalled
  u16s_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o)
  );

endmodule

[rtl/u16s_checker.sv]
// port-level checker for the utf-16be message text splitter
module u16s_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input u16s_pkg::out_word_t out_word_o
);
  import u16s_pkg::*;

  // done flag marks exactly the non-unit results
  a_done_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.message_done == (out_word_o.status != StUnit)))
    else $error("message_done does not match status");

  // every emitted unit belongs to the raw stream
  a_unit_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status == StUnit) |-> out_word_o.to_raw)
    else $error("unit word not on raw stream");

  // final words carry no unit
  a_final_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status != StUnit) |->
      (out_word_o.code_unit == 16'd0 && !out_word_o.to_raw && !out_word_o.to_display))
    else $error("final word carries unit data");

  // status code within the defined set
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.status <= StUnterm))
    else $error("undefined status code");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("output word changed while stalled");

endmodule

bind utf16be_message_text_splitter u16s_checker u_chk (.*);
